@@ src/html_char_reference_decoder_top_defines.svh @@
// assertion macros for the html character reference decoder
// used by the checker file only
`ifndef HTML_CHAR_REFERENCE_DECODER_TOP_DEFINES_SVH
`define HTML_CHAR_REFERENCE_DECODER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define HCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define HCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/hcrd_pkg.sv @@
// shared types and constants for the html character reference decoder
// no dependencies
package hcrd_pkg;
    localparam logic [15:0] SURR_HI   = 16'hd800;
    localparam logic [15:0] SURR_LO   = 16'hdc00;
    localparam logic [9:0]  SURR_MASK = 10'h3ff;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [7:0]  CONT_TAG  = 8'h80;
    localparam logic [7:0]  LEAD_TAG  = 8'hc0;
    localparam logic [7:0]  TAG_MASK  = 8'hc0;
    localparam logic [7:0]  BITS_MASK = 8'h3f;
    localparam logic [7:0]  SENTINEL  = 8'hff;
    localparam logic        OP_LOAD   = 1'b0;
    localparam logic        OP_CHAR   = 1'b1;

    // parse modes
    localparam logic [2:0] PM_START = 3'd0;
    localparam logic [2:0] PM_HASH  = 3'd1;
    localparam logic [2:0] PM_HEX0  = 3'd2;
    localparam logic [2:0] PM_HEX   = 3'd3;
    localparam logic [2:0] PM_DEC   = 3'd4;
    localparam logic [2:0] PM_NAMED = 3'd5;
    localparam logic [2:0] PM_BAD   = 3'd6;

    typedef logic [15:0] t_unit;

    function automatic logic is_name_byte(input logic [7:0] b);
        return (b[7] == 1'b0) && (b != 8'h3b);
    endfunction
endpackage

@@ src/hcrd_ram.sv @@
// generic single port ram with registered read
// no dependencies
module hcrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // registered read, old word returned on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ src/html_char_reference_decoder_top.sv @@
// html character reference decoder top level
// uses hcrd_pkg and hcrd_ram
//
// Usage: a beat is taken on i_clk when start is high and busy is low.
// op 0 writes i_table_byte at i_table_addr into the table ram
// and gives no result; addresses at or above TABLE_DEPTH are dropped.
// op 1 feeds one name character; a character that is not final holds busy
// through the parse step (S_CHW), so the next beat waits until it is done.
// On the final character the block decodes: a numeric form passes S_FIN and
// S_NUM before its first result, and a final beat other than ';' adds S_CHW.
// A named form runs a binary search over the table through the single table
// ram port: bound scans and compares use a read, wait and check state per
// byte visited, skip and decode a read and check; time grows with records.
// Results come out one per cycle with o_res_valid high for one cycle each,
// o_last on the final one; the receiver cannot stall them. Error gives one
// result with code unit 0 and status 1.
// Configuration: i_cfg_valid/o_cfg_ready write table_length; ready only when idle.
// Reset (synchronous, active low) clears the name state and sets
// table_length to 32768; the table ram itself is not cleared.
module html_char_reference_decoder_top
    import hcrd_pkg::*;
#(
    parameter int TABLE_DEPTH    = 32768,
    parameter int MAX_NAME       = 32,
    parameter int MAX_CODEPOINTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [14:0] i_table_addr,
    input  logic [7:0]  i_table_byte,
    input  logic [15:0] i_name_char,
    input  logic        i_final_req,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_res_valid,
    output logic [15:0] o_code_unit,
    output logic        o_status,
    output logic        o_last
);
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int NAW = $clog2(MAX_NAME);
    localparam int NLW = $clog2(MAX_NAME + 1) + 1;
    localparam int LW  = TAW + 1;
    localparam int CPW = $clog2(MAX_CODEPOINTS + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FIN   = 5'd1;
    localparam logic [4:0] S_MID   = 5'd2;
    localparam logic [4:0] S_PBR   = 5'd3;  // read pb
    localparam logic [4:0] S_PBW   = 5'd4;  // got pb byte, read pb-1
    localparam logic [4:0] S_PBC   = 5'd5;  // got pb-1
    localparam logic [4:0] S_PER   = 5'd6;
    localparam logic [4:0] S_PEW   = 5'd7;
    localparam logic [4:0] S_PEC   = 5'd8;
    localparam logic [4:0] S_CMPR  = 5'd9;
    localparam logic [4:0] S_CMPW  = 5'd10;
    localparam logic [4:0] S_CMPC  = 5'd11;
    localparam logic [4:0] S_SKR   = 5'd12;
    localparam logic [4:0] S_SKC   = 5'd13;
    localparam logic [4:0] S_CPR   = 5'd14;
    localparam logic [4:0] S_CPC   = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;
    localparam logic [4:0] S_ERR   = 5'd17;
    localparam logic [4:0] S_CHW   = 5'd18;
    localparam logic [4:0] S_NUM   = 5'd19;

    logic [4:0]      r_state, n_state;
    logic [15:0]     r_tlen;
    logic [NLW-1:0]  r_nlen, n_nlen;
    logic [31:0]     r_num, n_num;
    logic [2:0]      r_mode, n_mode;
    logic            r_inv, n_inv;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_beg, n_beg, r_end, n_end, r_mid, n_mid;
    logic [LW-1:0]   r_pb, n_pb, r_pe, n_pe, r_p, n_p;
    logic [NLW-1:0]  r_ci, n_ci;
    logic [7:0]      r_b0, n_b0;
    logic [31:0]     r_cp, n_cp;
    logic [CPW-1:0]  r_cps, n_cps;
    t_unit           r_u [4];
    t_unit           n_u [4];
    logic [2:0]      r_un, n_un, r_ue, n_ue;
    logic            r_done, n_done;   // payload finished after emit
    logic            r_fin, n_fin;
    logic [6:0]      r_ch, n_ch;

    // table ram
    logic            t_we;
    logic [TAW-1:0]  t_addr;
    logic [LW-1:0]   t_raddr;
    logic [7:0]      t_rdata, tb;
    logic            r_tvalid, n_tvalid;
    // name ram
    logic            nm_we;
    logic [NAW-1:0]  nm_addr;
    logic [6:0]      nm_wdata, nm_rdata;

    logic            acc;
    logic [LW-1:0]   len_c;

    hcrd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr), .i_wdata(i_table_byte),
        .o_rdata(t_rdata)
    );
    hcrd_ram #(.WIDTH(7), .DEPTH(MAX_NAME)) u_name (
        .i_clk(i_clk), .i_we(nm_we), .i_addr(nm_addr), .i_wdata(nm_wdata),
        .o_rdata(nm_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign acc         = start && !busy;
    // out-of-range bytes read as zero
    assign tb          = r_tvalid ? t_rdata : 8'd0;
    assign len_c       = (32'(r_tlen) > 32'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(r_tlen);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen <= 16'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tlen <= i_cfg_data;
        end
    end

    // digit helpers on the pending character
    function automatic logic [4:0] hexv(input logic [6:0] c);
        if (c >= 7'h30 && c <= 7'h39) return {1'b0, 4'(c - 7'h30)};
        if (c >= 7'h61 && c <= 7'h66) return {1'b0, 4'(c - 7'h57)};
        if (c >= 7'h41 && c <= 7'h46) return {1'b0, 4'(c - 7'h37)};
        return 5'h10;
    endfunction

    // main sequencer
    always_comb begin
        logic        nb, nbp;
        logic [LW-1:0] mid_c;
        logic [31:0] cx;
        logic [4:0]  hv;
        logic        dig;
        logic [31:0] v;
        n_state = r_state; n_nlen = r_nlen; n_num = r_num; n_mode = r_mode;
        n_inv = r_inv; n_len = r_len; n_beg = r_beg; n_end = r_end; n_mid = r_mid;
        n_pb = r_pb; n_pe = r_pe; n_p = r_p; n_ci = r_ci; n_b0 = r_b0;
        n_cp = r_cp; n_cps = r_cps; n_u = r_u; n_un = r_un; n_ue = r_ue;
        n_done = r_done; n_fin = r_fin; n_ch = r_ch;
        t_we = 1'b0; t_raddr = '0; nm_we = 1'b0; nm_wdata = r_ch;
        nm_addr = r_ci[NAW-1:0];
        o_res_valid = 1'b0; o_code_unit = 16'd0; o_status = 1'b0; o_last = 1'b0;
        nb = 1'b0; nbp = 1'b0; mid_c = '0; cx = 32'd0; v = '0;
        hv = hexv(r_ch);
        dig = (r_ch >= 7'h30) && (r_ch <= 7'h39);
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_op == OP_LOAD) begin
                        t_we = (32'(i_table_addr) < 32'(TABLE_DEPTH));
                        t_raddr = LW'(i_table_addr);
                    end else begin
                        n_ch  = i_name_char[6:0];
                        n_fin = i_final_req;
                        if (!(i_final_req && i_name_char == 16'h003b)) begin
                            if (i_name_char > 16'h7f || i_name_char == 16'h003b) begin
                                n_inv = 1'b1;
                            end
                            if (r_nlen >= NLW'(MAX_NAME)) begin
                                n_inv = 1'b1;
                            end else begin
                                nm_we   = 1'b1;
                                nm_addr = r_nlen[NAW-1:0];
                                nm_wdata = i_name_char[6:0];
                                n_nlen  = r_nlen + 1'b1;
                            end
                            n_state = S_CHW;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            // advance parse mode on the pending character
            S_CHW: begin
                unique case (r_mode)
                    PM_START: n_mode = (r_ch == 7'h23) ? PM_HASH : PM_NAMED;
                    PM_HASH: begin
                        if (r_ch == 7'h78 || r_ch == 7'h58) n_mode = PM_HEX0;
                        else if (dig) begin
                            n_mode = PM_DEC; n_num = 32'(hv[3:0]);
                        end else n_mode = PM_BAD;
                    end
                    PM_HEX0, PM_HEX: begin
                        if (!hv[4]) begin
                            n_mode = PM_HEX; n_num = {r_num[27:0], hv[3:0]};
                        end else n_mode = PM_BAD;
                    end
                    PM_DEC: begin
                        if (dig) n_num = {r_num[28:0], 3'b0} + {r_num[30:0], 1'b0}
                                         + 32'(hv[3:0]);
                        else n_mode = PM_BAD;
                    end
                    default: ;
                endcase
                n_state = r_fin ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                n_un = '0; n_ue = '0; n_cps = '0;
                n_len = len_c; n_beg = LW'(1); n_end = len_c;
                if (r_inv || r_nlen == '0) n_state = S_ERR;
                else if (r_mode == PM_HEX || r_mode == PM_DEC) n_state = S_NUM;
                else if (r_mode == PM_NAMED && len_c >= LW'(2)) n_state = S_MID;
                else n_state = S_ERR;
            end
            S_NUM: begin
                if (r_num < 32'h10000) begin
                    n_u[0] = r_num[15:0]; n_un = 3'd1;
                end else begin
                    cx = r_num - 32'h10000;
                    n_u[0] = SURR_HI | {6'd0, cx[19:10] & SURR_MASK};
                    n_u[1] = SURR_LO | {6'd0, cx[9:0]};
                    n_un = 3'd2;
                end
                n_done = 1'b1; n_state = S_EMIT;
            end
            S_MID: begin
                if (r_beg < r_end) begin
                    mid_c = r_beg + ((r_end - r_beg) >> 1);
                    n_mid = mid_c; n_pb = mid_c; n_pe = mid_c + 1'b1;
                    n_state = S_PBR;
                end else n_state = S_ERR;
            end
            // walk pb back to a record start
            S_PBR: begin
                t_raddr = r_pb; n_state = S_PBW;
            end
            S_PBW: begin
                n_b0 = tb; t_raddr = r_pb - 1'b1; n_state = S_PBC;
            end
            S_PBC: begin
                nb = is_name_byte(r_b0); nbp = is_name_byte(tb);
                if (r_pb > r_beg && (!nb || nbp)) begin
                    n_pb = r_pb - 1'b1; n_state = S_PBR;
                end else n_state = S_PER;
            end
            // walk pe forward to the next record start
            S_PER: begin
                t_raddr = r_pe - 1'b1; n_state = S_PEW;
            end
            S_PEW: begin
                n_b0 = tb; t_raddr = r_pe; n_state = S_PEC;
            end
            S_PEC: begin
                nbp = is_name_byte(r_b0); nb = is_name_byte(tb);
                if (r_pe < r_end && (nbp || !nb)) begin
                    n_pe = r_pe + 1'b1; n_state = S_PER;
                end else begin
                    n_ci = '0; n_state = S_CMPR;
                end
            end
            // compare name with record, one byte per pass through S_CMPR, S_CMPW and S_CMPC
            S_CMPR: begin
                t_raddr = r_pb + LW'(r_ci); nm_addr = r_ci[NAW-1:0];
                n_state = S_CMPW;
            end
            S_CMPW: begin
                nb = is_name_byte(tb);
                if (r_ci >= r_nlen || !nb) begin
                    if (r_ci >= r_nlen && !nb) begin
                        n_p = r_pb; n_state = S_SKR;
                    end else if (r_ci >= r_nlen) begin
                        n_end = r_pb; n_state = S_MID;
                    end else begin
                        n_beg = r_pe; n_state = S_MID;
                    end
                end else if ({1'b0, nm_rdata} != tb) begin
                    if ({1'b0, nm_rdata} < tb) n_end = r_pb;
                    else n_beg = r_pe;
                    n_state = S_MID;
                end else begin
                    n_ci = r_ci + 1'b1; n_state = S_CMPC;
                end
            end
            S_CMPC: begin
                n_state = S_CMPR;
            end
            // skip name bytes of the matched record
            S_SKR: begin
                t_raddr = r_p; n_state = S_SKC;
            end
            S_SKC: begin
                if (r_p < r_len && is_name_byte(tb)) begin
                    n_p = r_p + 1'b1; n_state = S_SKR;
                end else begin
                    n_cp = '0; n_b0 = 8'd0; n_state = S_CPR;
                    n_ci = '0;
                end
            end
            // codepoint decode: first byte then continuation bytes
            S_CPR: begin
                t_raddr = r_p; n_state = S_CPC;
            end
            S_CPC: begin
                if (r_ci == '0) begin
                    n_cp = {26'd0, tb[5:0]}; n_p = r_p + 1'b1; n_ci = NLW'(1);
                    n_state = S_CPR;
                end else if (r_p < r_len && (tb & TAG_MASK) == CONT_TAG) begin
                    n_cp = {r_cp[25:0], tb[5:0]}; n_p = r_p + 1'b1;
                    n_state = S_CPR;
                end else begin
                    n_ci = '0;
                    n_state = S_CPR;
                    if (r_cp < 32'(SUPP_BASE)) begin
                        if (r_un + 3'd1 > 3'd4) begin
                            n_done = 1'b1; n_state = S_EMIT;
                        end else begin
                            n_u[r_un[1:0]] = r_cp[15:0]; n_un = r_un + 3'd1;
                        end
                    end else begin
                        v = r_cp - 32'(SUPP_BASE);
                        if (r_un + 3'd2 > 3'd4) begin
                            n_done = 1'b1; n_state = S_EMIT;
                        end else begin
                            n_u[r_un[1:0]] = SURR_HI | {6'd0, v[19:10]};
                            n_u[2'(r_un + 3'd1)] = SURR_LO | {6'd0, v[9:0]};
                            n_un = r_un + 3'd2;
                        end
                    end
                    if (n_state == S_CPR) begin
                        n_cps = r_cps + 1'b1;
                        if (n_cps >= CPW'(MAX_CODEPOINTS) || r_p >= r_len
                            || (tb & TAG_MASK) != LEAD_TAG) begin
                            n_state = S_EMIT;
                        end
                    end
                    if (n_state == S_EMIT && n_un == 3'd0) n_state = S_ERR;
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                o_code_unit = r_u[r_ue[1:0]];
                o_last = (r_ue + 3'd1 == r_un);
                n_ue = r_ue + 3'd1;
                if (o_last) begin
                    n_state = S_IDLE; n_nlen = '0; n_num = '0; n_mode = PM_START;
                    n_inv = 1'b0; n_done = 1'b0;
                end
            end
            S_ERR: begin
                o_res_valid = 1'b1; o_status = 1'b1; o_last = 1'b1;
                n_state = S_IDLE; n_nlen = '0; n_num = '0; n_mode = PM_START;
                n_inv = 1'b0; n_done = 1'b0;
            end
            default: n_state = S_IDLE;
        endcase
        n_tvalid = (t_raddr < r_len) || (r_state == S_IDLE);
        t_addr   = (acc && (i_op == OP_LOAD)) ? TAW'(i_table_addr) : t_raddr[TAW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_nlen <= '0; r_num <= '0; r_mode <= PM_START;
            r_inv <= 1'b0; r_done <= 1'b0; r_fin <= 1'b0; r_ue <= '0; r_un <= '0;
        end else begin
            r_state <= n_state; r_nlen <= n_nlen; r_num <= n_num; r_mode <= n_mode;
            r_inv <= n_inv; r_done <= n_done; r_fin <= n_fin; r_ue <= n_ue;
            r_un <= n_un;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_len <= n_len; r_beg <= n_beg; r_end <= n_end; r_mid <= n_mid;
        r_pb <= n_pb; r_pe <= n_pe; r_p <= n_p; r_ci <= n_ci; r_b0 <= n_b0;
        r_cp <= n_cp; r_cps <= n_cps; r_u <= n_u; r_ch <= n_ch;
        r_tvalid <= n_tvalid;
    end
endmodule

@@ src/hcrd_checker.sv @@
// port level checker for the html character reference decoder
// uses html_char_reference_decoder_top_defines.svh
`include "html_char_reference_decoder_top_defines.svh"
module hcrd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_cfg_ready,
    input logic o_res_valid,
    input logic o_status,
    input logic o_last,
    input logic [15:0] o_code_unit
);
    `HCR_ASSERT_IMPL(a_err_single, i_clk, i_rst_n, o_res_valid && o_status, o_last && o_code_unit == 16'd0, "error beat must be single and zero")
    `HCR_ASSERT_IMPL(a_res_busy, i_clk, i_rst_n, o_res_valid, busy, "result outside busy")
    `HCR_ASSERT_IMPL(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !busy, "config taken while busy")
    `HCR_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_res_valid && o_last, !busy, "not idle after last beat")
endmodule

bind html_char_reference_decoder_top hcrd_checker u_hcrd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .o_cfg_ready(o_cfg_ready),
    .o_res_valid(o_res_valid), .o_status(o_status), .o_last(o_last),
    .o_code_unit(o_code_unit)
);
